[hdl/depth_histogram_colorizer_macros.svh]
// Assertion macros for the depth histogram colorizer.
`ifndef DEPTH_HISTOGRAM_COLORIZER_MACROS_SVH
`define DEPTH_HISTOGRAM_COLORIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DHC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DHC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/dhc_pkg.sv]
// ----------------------------------------------------------------------------
// dhc_pkg
// Shared constants, palette table and divider request type.
// ----------------------------------------------------------------------------
package dhc_pkg;

  localparam int unsigned HistBins    = 65536;
  localparam int unsigned CountBits   = 20;
  localparam int unsigned PaletteSize = 10;
  localparam int unsigned Div10Mul    = 52429;
  localparam int unsigned Div10Shift  = 19;

  typedef struct packed {
    logic        start;
    logic [23:0] color;
  } div_req_t;

  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] c;
    case (idx)
      4'd0:    c = 24'd16777215;
      4'd1:    c = 24'd14565387;
      4'd2:    c = 24'd32255;
      4'd3:    c = 24'd7996159;
      4'd4:    c = 24'd16530175;
      4'd5:    c = 24'd8373026;
      4'd6:    c = 24'd14590399;
      4'd7:    c = 24'd7062435;
      4'd8:    c = 24'd13951499;
      4'd9:    c = 24'd55807;
      default: c = 24'd0;
    endcase
    return c;
  endfunction

endpackage

[hdl/depth_histogram_colorizer.sv]
// ----------------------------------------------------------------------------
// depth_histogram_colorizer
// Depth histogram with cumulative-sum colormap over a user palette.
// ----------------------------------------------------------------------------
// One item is worked on at a time around the single-port-pair histogram
// memory. After reset a clearing pass over all HIST_BINS entries runs before
// the first item is taken. A count item steps through accept, read and write
// back; an empty sample skips the write back. The first count after coloring
// adds a clearing pass. A color item runs through the bit-serial divider (one
// quotient bit per cycle); black pixels skip it. The first color item after
// counting adds a running-sum sweep. The result register lets the next item
// enter while a pixel waits.
`include "depth_histogram_colorizer_macros.svh"

module depth_histogram_colorizer #(
  parameter int unsigned HIST_BINS  = dhc_pkg::HistBins,
  parameter int unsigned COUNT_BITS = dhc_pkg::CountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [15:0] depth_i,
  input  logic [15:0] user_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);

  localparam int unsigned IW = $clog2(HIST_BINS);
  localparam int unsigned CB = COUNT_BITS;
  localparam logic [IW-1:0] LastIdx = IW'(HIST_BINS - 1);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CNT_RD  = 4'd2;
  localparam logic [3:0] S_CNT_WR  = 4'd3;
  localparam logic [3:0] S_SUM     = 4'd4;
  localparam logic [3:0] S_COL_RD  = 4'd5;
  localparam logic [3:0] S_COL_CHK = 4'd6;
  localparam logic [3:0] S_COL_DIV = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  logic [3:0]    state_q;
  logic          pend_q;
  logic          sums_ready_q;
  logic [CB-1:0] total_q;
  logic [IW-1:0] sweep_q;
  logic [IW-1:0] wr_idx_q;
  logic          sum_v_q;
  logic          rd_done_q;
  logic [CB-1:0] run_q;
  logic [IW-1:0] idx_q;
  logic          depth_nz_q;
  logic [15:0]   user_q;
  logic [12:0]   quo10_q;
  logic [23:0]   res_q;
  logic          out_valid_q;
  logic [23:0]   out_q;

  logic          in_xfer;
  logic [IW-1:0] in_idx;
  logic [31:0]   user_prod;
  logic [CB-1:0] rdata;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [CB-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [CB:0]   inc_ext;
  logic [CB:0]   add_ext;
  logic [CB:0]   tot_ext;
  logic [CB-1:0] inc_sat;
  logic [CB-1:0] add_sat;
  logic [CB-1:0] tot_sat;
  logic [15:0]   user_rem;
  logic          black;
  dhc_pkg::div_req_t div_req;
  logic          div_done;
  logic [23:0]   div_rgb;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_idx     = (32'(depth_i) >= HIST_BINS) ? LastIdx : depth_i[IW-1:0];
  assign user_prod  = 32'(user_id_i) * 32'(dhc_pkg::Div10Mul);

  assign inc_ext = {1'b0, rdata} + (CB+1)'(1);
  assign add_ext = {1'b0, run_q} + {1'b0, rdata};
  assign tot_ext = {1'b0, total_q} + (CB+1)'(1);
  assign inc_sat = inc_ext[CB] ? '1 : inc_ext[CB-1:0];
  assign add_sat = add_ext[CB] ? '1 : add_ext[CB-1:0];
  assign tot_sat = tot_ext[CB] ? '1 : tot_ext[CB-1:0];

  assign user_rem = user_q - 16'(quo10_q) * 16'(dhc_pkg::PaletteSize);
  assign black    = !depth_nz_q || (total_q == '0) || (rdata > total_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;
    mem_raddr = idx_q;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
      end
      S_CNT_WR: begin
        mem_we    = depth_nz_q;
        mem_wdata = inc_sat;
      end
      S_SUM: begin
        mem_raddr = sweep_q;
        mem_we    = sum_v_q;
        mem_waddr = wr_idx_q;
        mem_wdata = add_sat;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    div_req.start = (state_q == S_COL_CHK) && !black;
    div_req.color = dhc_pkg::palette(user_rem[3:0]);
  end

  dhc_hist_mem #(
    .Depth (HIST_BINS),
    .Width (CB)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  dhc_div #(
    .CountBits (CB)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (total_q - rdata),
    .den_i  (total_q),
    .done_o (div_done),
    .rgb_o  (div_rgb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      pend_q       <= 1'b0;
      sums_ready_q <= 1'b0;
      total_q      <= '0;
      sweep_q      <= '0;
      sum_v_q      <= 1'b0;
      rd_done_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          sweep_q <= sweep_q + IW'(1);
          if (sweep_q == LastIdx) begin
            sweep_q <= '0;
            if (pend_q) begin
              pend_q       <= 1'b0;
              sums_ready_q <= 1'b0;
              total_q      <= '0;
              state_q      <= S_CNT_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            if (!opcode_i) begin
              if (sums_ready_q) begin
                pend_q  <= 1'b1;
                sweep_q <= '0;
                state_q <= S_CLR;
              end else begin
                state_q <= S_CNT_RD;
              end
            end else if (!sums_ready_q) begin
              sweep_q   <= '0;
              sum_v_q   <= 1'b0;
              rd_done_q <= 1'b0;
              state_q   <= S_SUM;
            end else begin
              state_q <= S_COL_RD;
            end
          end
        end
        S_CNT_RD: begin
          state_q <= depth_nz_q ? S_CNT_WR : S_IDLE;
        end
        S_CNT_WR: begin
          total_q <= tot_sat;
          state_q <= S_IDLE;
        end
        S_SUM: begin
          if (!rd_done_q) begin
            sum_v_q <= 1'b1;
            if (sweep_q == LastIdx) begin
              rd_done_q <= 1'b1;
            end else begin
              sweep_q <= sweep_q + IW'(1);
            end
          end else if (sum_v_q) begin
            sum_v_q      <= 1'b0;
            sums_ready_q <= 1'b1;
            state_q      <= S_COL_RD;
          end
        end
        S_COL_RD: begin
          state_q <= S_COL_CHK;
        end
        S_COL_CHK: begin
          state_q <= black ? S_OUT : S_COL_DIV;
        end
        S_COL_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      idx_q      <= in_idx;
      depth_nz_q <= (depth_i != 16'd0);
      user_q     <= user_id_i;
      quo10_q    <= user_prod[31:dhc_pkg::Div10Shift];
    end
    if (state_q == S_SUM) begin
      if (!rd_done_q) begin
        wr_idx_q <= sweep_q;
      end
      if (sum_v_q) begin
        run_q <= add_sat;
      end
    end
    if (state_q == S_IDLE) begin
      run_q <= '0;
    end
    if (state_q == S_COL_CHK) begin
      res_q <= '0;
    end
    if ((state_q == S_COL_DIV) && div_done) begin
      res_q <= div_rgb;
    end
    if ((state_q == S_OUT) && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_q[7:0];
  assign green_o     = out_q[15:8];
  assign blue_o      = out_q[23:16];

  `DHC_ASSERT_NXT(a_accept_leaves_idle, clk_i, rst_ni, in_xfer, state_q != S_IDLE)
  `DHC_ASSERT_NOW(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == S_COL_DIV)
  `DHC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, (state_q == S_OUT) && out_valid_q && !out_ready_i, state_q == S_OUT)
  `DHC_ASSERT_NXT(a_total_write, clk_i, rst_ni, (state_q != S_CNT_WR) && (state_q != S_CLR), $stable(total_q))

endmodule

[hdl/dhc_hist_mem.sv]
// ----------------------------------------------------------------------------
// dhc_hist_mem
// Histogram store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dhc_hist_mem #(
  parameter int unsigned Depth = dhc_pkg::HistBins,
  parameter int unsigned Width = dhc_pkg::CountBits
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/dhc_div.sv]
// ----------------------------------------------------------------------------
// dhc_div
// Three-lane restoring divider: floor(byte * num / den) for each color byte.
// ----------------------------------------------------------------------------
module dhc_div #(
  parameter int unsigned CountBits = dhc_pkg::CountBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dhc_pkg::div_req_t     req_i,
  input  logic [CountBits-1:0]  num_i,
  input  logic [CountBits-1:0]  den_i,
  output logic                  done_o,
  output logic [23:0]           rgb_o
);

  localparam int unsigned DW = CountBits + 8;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0]        dq_q  [3];
  logic [CountBits-1:0] rem_q [3];
  logic [CountBits-1:0] den_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q;
  logic                 done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic [CountBits:0] sh;
    logic               ge;
    logic [CountBits:0] diff;

    assign sh   = {rem_q[j], dq_q[j][DW-1]};
    assign ge   = sh >= {1'b0, den_q};
    assign diff = sh - {1'b0, den_q};

    always_ff @(posedge clk_i) begin
      if (req_i.start) begin
        dq_q[j]  <= DW'(req_i.color[8*j +: 8]) * DW'(num_i);
        rem_q[j] <= '0;
      end else if (busy_q) begin
        rem_q[j] <= ge ? diff[CountBits-1:0] : sh[CountBits-1:0];
        dq_q[j]  <= {dq_q[j][DW-2:0], ge};
      end
    end

    assign rgb_o[8*j +: 8] = dq_q[j][7:0];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the depth histogram colorizer. Frames of depth
// counts and pixel colorings go in over valid/ready; a cycle-free model of
// the histogram, its running sums and the palette scaling predicts every
// pixel, and the monitor compares each transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  typedef enum logic {OP_COUNT = 1'b0, OP_COLOR = 1'b1} op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] depth;
    logic [15:0] user;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam int unsigned CntMax = (1 << dhc_pkg::CountBits) - 1;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        opcode_i;
  logic [15:0] depth_i;
  logic [15:0] user_id_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;

  depth_histogram_colorizer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .depth_i    (depth_i),
    .user_id_i  (user_id_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o)
  );

  pix_item_t   pending_items[$];
  rgb_t        expected_pixels[$];
  int unsigned hist_bins[dhc_pkg::HistBins];
  int unsigned hist_points;
  bit          hist_summed;
  int          mismatches;
  int          sent_items;
  int          hold_cycles;
  bit          hold_fired;

  function automatic logic [7:0] scale_channel(int unsigned chan, int unsigned num,
                                               int unsigned den);
    longint unsigned p;
    p = longint'(chan) * num;
    return 8'(p / den);
  endfunction

  function automatic void model_item(pix_item_t it);
    int unsigned     cum;
    int unsigned     num;
    longint unsigned run;
    logic [23:0]     c;
    rgb_t            px;
    if (it.op == OP_COUNT) begin
      if (hist_summed) begin
        foreach (hist_bins[i]) hist_bins[i] = 0;
        hist_points = 0;
        hist_summed = 0;
      end
      if (it.depth != 0) begin
        if (hist_bins[it.depth] < CntMax) hist_bins[it.depth]++;
        if (hist_points < CntMax) hist_points++;
      end
    end else begin
      if (!hist_summed) begin
        run = 0;
        foreach (hist_bins[i]) begin
          run += hist_bins[i];
          if (run > CntMax) run = CntMax;
          hist_bins[i] = int'(run);
        end
        hist_summed = 1;
      end
      px = '0;
      if (it.depth != 0 && hist_points != 0) begin
        cum = hist_bins[it.depth];
        if (cum <= hist_points) begin
          num  = hist_points - cum;
          c    = dhc_pkg::palette(4'(it.user % dhc_pkg::PaletteSize));
          px.r = scale_channel(c[7:0], num, hist_points);
          px.g = scale_channel(c[15:8], num, hist_points);
          px.b = scale_channel(c[23:16], num, hist_points);
        end
      end
      expected_pixels.insert(expected_pixels.size(), px);
    end
  endfunction

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // sender: idle 35% then 85% then never
  always @(posedge clk_i) begin
    int pct;
    pct = sent_items < 150 ? 35 : (sent_items < 300 ? 85 : 0);
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        model_item('{op: op_e'(opcode_i), depth: depth_i, user: user_id_i});
        sent_items <= sent_items + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() > 0 && $urandom_range(99, 0) >= pct) begin
          pix_item_t it;
          it = pending_items.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= it.op;
          depth_i    <= it.depth;
          user_id_i  <= it.user;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  always @(posedge clk_i) begin
    if (!hold_fired && sent_items >= 240) begin
      hold_fired  <= 1'b1;
      hold_cycles <= 400;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  always @(posedge clk_i) begin
    int pct;
    pct = sent_items < 150 ? 85 : (sent_items < 300 ? 35 : 0);
    if (rst_ni) begin
      out_ready_i <= (hold_cycles == 0) && ($urandom_range(99, 0) >= pct);
    end
  end

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel r=%0d g=%0d b=%0d",
                                       red_o, green_o, blue_o);
      end else begin
        want = expected_pixels.pop_front();
        if (want.r !== red_o || want.g !== green_o || want.b !== blue_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     want.r, want.g, want.b, red_o, green_o, blue_o);
        end
      end
    end
  end

  function automatic logic [15:0] pick_depth();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 10) return 16'd0;
    if (sel < 80) return 16'($urandom_range(2000, 1));
    return 16'($urandom_range(65535, 0));
  endfunction

  task automatic push_item(op_e op, logic [15:0] d, logic [15:0] u);
    pending_items.insert(pending_items.size(), '{op: op, depth: d, user: u});
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_pixels.size() > 0)
      @(negedge clk_i);
  endtask

  task automatic random_frame(int n_count, int n_color);
    for (int i = 0; i < n_count; i++)
      push_item(OP_COUNT, pick_depth(), 16'($urandom_range(65535, 0)));
    for (int i = 0; i < n_color; i++) begin
      if ($urandom_range(19, 0) == 0)
        push_item(OP_COUNT, pick_depth(), 16'($urandom_range(65535, 0)));
      else
        push_item(OP_COLOR, pick_depth(), 16'($urandom_range(65535, 0)));
    end
  endtask

  initial begin
    in_valid_i  = 1'b0;
    opcode_i    = 1'b0;
    depth_i     = '0;
    user_id_i   = '0;
    out_ready_i = 1'b0;
    rst_ni      = 1'b0;
    mismatches  = 0;
    sent_items  = 0;
    hold_cycles = 0;
    hold_fired  = 1'b0;
    hist_points = 0;
    hist_summed = 1'b0;
    foreach (hist_bins[i]) hist_bins[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // color with nothing counted
    push_item(OP_COLOR, 16'd100, 16'd0);
    push_item(OP_COLOR, 16'd0, 16'd3);
    wait_drained();

    push_item(OP_COUNT, 16'd0, 16'd0);
    push_item(OP_COUNT, 16'd1, 16'hFFFF);
    push_item(OP_COUNT, 16'd65535, 16'd0);
    push_item(OP_COUNT, 16'd1000, 16'd5);
    push_item(OP_COUNT, 16'd1000, 16'd5);
    push_item(OP_COUNT, 16'd500, 16'd5);
    for (int u = 0; u < 10; u++) push_item(OP_COLOR, 16'(u * 150), 16'(u));
    push_item(OP_COLOR, 16'd1, 16'hFFFF);
    push_item(OP_COLOR, 16'd65535, 16'd7);
    push_item(OP_COLOR, 16'd0, 16'd1);
    push_item(OP_COLOR, 16'd999, 16'd0);
    wait_drained();

    // only empty samples: no points in frame
    push_item(OP_COUNT, 16'd0, 16'd0);
    push_item(OP_COUNT, 16'd0, 16'd9);
    push_item(OP_COLOR, 16'd10, 16'd0);
    push_item(OP_COLOR, 16'd65535, 16'd4);
    wait_drained();

    for (int f = 0; f < 3; f++) begin
      random_frame(60, 80);
      wait_drained();
    end
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1000ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/dhc_pkg.sv
hdl/dhc_hist_mem.sv
hdl/dhc_div.sv
hdl/depth_histogram_colorizer.sv
verif/tb.sv
